// ===== rtl/mlcd_pkg.sv =====
package mlcd_pkg;

    localparam int OPC_W  = 3;
    localparam int X_W    = 7;
    localparam int Y_W    = 7;
    localparam int BYTE_W = 8;
    localparam int LINE_W = 8;

    localparam logic [OPC_W-1:0] OPC_DRAW   = 3'd0;
    localparam logic [OPC_W-1:0] OPC_READ   = 3'd1;
    localparam logic [OPC_W-1:0] OPC_CLEAR  = 3'd2;
    localparam logic [OPC_W-1:0] OPC_UPDATE = 3'd3;
    localparam logic [OPC_W-1:0] OPC_TICK   = 3'd4;
    localparam logic [OPC_W-1:0] OPC_PANEL  = 3'd5;
    localparam logic [OPC_W-1:0] OPC_NEXT   = 3'd6;

    localparam logic [BYTE_W-1:0] MODE_UPDATE = 8'h80;
    localparam logic [BYTE_W-1:0] VCOM_BIT    = 8'h40;
    localparam logic [BYTE_W-1:0] CMD_CLEAR   = 8'h20;
    localparam logic [BYTE_W-1:0] DUMMY_BYTE  = 8'hFF;
    localparam logic [BYTE_W-1:0] PAD_BYTE    = 8'h00;
    localparam logic [BYTE_W-1:0] PIXEL_MSB   = 8'h80;

    typedef enum logic [2:0] {
        OP_DRAW,
        OP_READ,
        OP_CLEAR,
        OP_UPDATE,
        OP_TICK,
        OP_PANEL,
        OP_NEXT,
        OP_BAD
    } t_op;

    typedef enum logic [1:0] {
        KIND_IDLE,
        KIND_FRAME,
        KIND_CMD
    } t_kind;

    typedef enum logic [1:0] {
        PEND_DRAW,
        PEND_READ,
        PEND_FRAME
    } t_pend;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_FETCH,
        ST_MEM
    } t_back_state;

    typedef struct packed {
        t_op              op;
        logic             in_range;
        logic [X_W-1:0]   x;
        logic [Y_W-1:0]   y;
        logic             color;
    } t_cmd;

    typedef struct packed {
        logic              pixel_value;
        logic              accepted;
        logic              link_valid;
        logic [BYTE_W-1:0] link_byte;
        logic              select_active;
        logic              transfer_last;
    } t_rsp;

    typedef struct packed {
        logic clearing;
    } t_back_status;

    function automatic logic [BYTE_W-1:0] bit_rev(input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] r;
        for (int i = 0; i < BYTE_W; i++) begin
            r[i] = b[BYTE_W-1-i];
        end
        return r;
    endfunction

endpackage

// ===== rtl/mlcd_if.sv =====
interface mlcd_cmd_if;
    logic                          valid;
    logic                          ready;
    logic [mlcd_pkg::OPC_W-1:0]    opcode;
    logic [mlcd_pkg::X_W-1:0]      x;
    logic [mlcd_pkg::Y_W-1:0]      y;
    logic                          color;

    modport source (output valid, output opcode, output x, output y, output color,
                    input ready);
    modport sink (input valid, input opcode, input x, input y, input color,
                  output ready);
endinterface

interface mlcd_rsp_if;
    logic                          valid;
    logic                          ready;
    logic                          pixel_value;
    logic                          accepted;
    logic                          link_valid;
    logic [mlcd_pkg::BYTE_W-1:0]   link_byte;
    logic                          select_active;
    logic                          transfer_last;

    modport source (output valid, output pixel_value, output accepted, output link_valid,
                    output link_byte, output select_active, output transfer_last,
                    input ready);
    modport sink (input valid, input pixel_value, input accepted, input link_valid,
                  input link_byte, input select_active, input transfer_last,
                  output ready);
endinterface

// ===== rtl/mlcd_ram.sv =====
module mlcd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/mlcd_fifo.sv =====
module mlcd_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  mlcd_pkg::t_cmd  i_data,
    output logic            o_ready,
    output logic            o_valid,
    output mlcd_pkg::t_cmd  o_data,
    input  logic            i_pop
);

    mlcd_pkg::t_cmd r_slots [2];
    logic           r_wr;
    logic           r_rd;
    logic [1:0]     r_count;
    logic [1:0]     n_count;

    assign o_ready = (r_count != 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_slots[r_rd];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slots[r_wr] <= i_data;
        end
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= ~r_wr;
            end
            if (i_pop) begin
                r_rd <= ~r_rd;
            end
            r_count <= n_count;
        end
    end

endmodule

// ===== rtl/mlcd_front.sv =====
module mlcd_front #(
    parameter int LINES          = 128,
    parameter int BYTES_PER_LINE = 16
) (
    mlcd_cmd_if.sink                i_cmd,
    input  mlcd_pkg::t_back_status  i_status,
    input  logic                    i_queue_ready,
    output logic                    o_push,
    output mlcd_pkg::t_cmd          o_item
);

    mlcd_pkg::t_op w_op;
    logic          w_in_range;

    always_comb begin
        case (i_cmd.opcode)
            mlcd_pkg::OPC_DRAW:   w_op = mlcd_pkg::OP_DRAW;
            mlcd_pkg::OPC_READ:   w_op = mlcd_pkg::OP_READ;
            mlcd_pkg::OPC_CLEAR:  w_op = mlcd_pkg::OP_CLEAR;
            mlcd_pkg::OPC_UPDATE: w_op = mlcd_pkg::OP_UPDATE;
            mlcd_pkg::OPC_TICK:   w_op = mlcd_pkg::OP_TICK;
            mlcd_pkg::OPC_PANEL:  w_op = mlcd_pkg::OP_PANEL;
            mlcd_pkg::OPC_NEXT:   w_op = mlcd_pkg::OP_NEXT;
            default:              w_op = mlcd_pkg::OP_BAD;
        endcase
    end

    // A pixel outside the panel is flagged here so the back end skips the store.
    assign w_in_range = ({1'b0, i_cmd.y} < mlcd_pkg::LINE_W'(LINES)) &&
                        ({3'b000, i_cmd.x[6:3]} < 7'(BYTES_PER_LINE));

    // No words are taken while the store is being swept.
    assign i_cmd.ready = i_queue_ready && !i_status.clearing;
    assign o_push      = i_cmd.valid && i_cmd.ready;

    always_comb begin
        o_item.op       = w_op;
        o_item.in_range = w_in_range;
        o_item.x        = i_cmd.x;
        o_item.y        = i_cmd.y;
        o_item.color    = i_cmd.color;
    end

endmodule

// ===== rtl/mlcd_back.sv =====
module mlcd_back #(
    parameter int LINES          = 128,
    parameter int BYTES_PER_LINE = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    input  mlcd_pkg::t_cmd          i_item,
    output logic                    o_pop,
    output mlcd_pkg::t_back_status  o_status,
    mlcd_rsp_if.source              o_rsp
);

    localparam int DEPTH  = LINES * BYTES_PER_LINE;
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SLOT_W = $clog2(BYTES_PER_LINE + 2);
    localparam int LW     = mlcd_pkg::LINE_W;
    localparam int BW     = mlcd_pkg::BYTE_W;

    mlcd_pkg::t_back_state r_state, n_state;
    logic [AW-1:0]         r_clr_addr, n_clr_addr;
    logic                  r_vcom, n_vcom;
    logic                  r_busy, n_busy;
    mlcd_pkg::t_kind       r_kind, n_kind;
    logic [BW-1:0]         r_head, n_head;
    logic                  r_first, n_first;
    logic [LW-1:0]         r_line, n_line;
    logic [SLOT_W-1:0]     r_slot, n_slot;
    logic [AW-1:0]         r_faddr, n_faddr;
    mlcd_pkg::t_pend       r_pend, n_pend;
    logic [BW-1:0]         r_mask, n_mask;
    logic                  r_color, n_color;
    logic [AW-1:0]         r_addr, n_addr;
    logic                  r_out_valid, n_out_valid;
    mlcd_pkg::t_rsp        r_rsp, n_rsp;

    logic                  w_pop;
    logic                  w_frame_data;
    logic                  w_pix_op;
    logic                  w_mem_op;
    logic [AW-1:0]         w_paddr;
    logic [BW-1:0]         w_pmask;
    logic                  w_we;
    logic [AW-1:0]         w_waddr;
    logic [BW-1:0]         w_wdata;
    logic [AW-1:0]         w_raddr;
    logic [BW-1:0]         w_rdata;
    mlcd_pkg::t_rsp        w_rsp;

    mlcd_ram #(
        .WIDTH (BW),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_pop = (r_state == mlcd_pkg::ST_FETCH) && i_valid &&
                   (!r_out_valid || o_rsp.ready);
    assign o_pop = w_pop;
    assign o_status.clearing = (r_state == mlcd_pkg::ST_CLEAR);

    assign w_paddr = AW'(({25'b0, i_item.y} * BYTES_PER_LINE) + {28'b0, i_item.x[6:3]});
    assign w_pmask = mlcd_pkg::PIXEL_MSB >> i_item.x[2:0];

    // A frame data byte is the only link byte that needs a store read.
    assign w_frame_data = r_busy && (r_kind == mlcd_pkg::KIND_FRAME) && !r_first &&
                          (r_line != LW'(LINES)) && (r_slot != '0) &&
                          (r_slot <= SLOT_W'(BYTES_PER_LINE));
    assign w_pix_op = ((i_item.op == mlcd_pkg::OP_DRAW) ||
                       (i_item.op == mlcd_pkg::OP_READ)) && i_item.in_range;
    assign w_mem_op = w_pix_op || ((i_item.op == mlcd_pkg::OP_NEXT) && w_frame_data);

    always_comb begin
        n_state = r_state;
        case (r_state)
            mlcd_pkg::ST_CLEAR: begin
                if (r_clr_addr == AW'(DEPTH - 1)) begin
                    n_state = mlcd_pkg::ST_FETCH;
                end
            end
            mlcd_pkg::ST_FETCH: begin
                if (w_pop) begin
                    if (w_mem_op) begin
                        n_state = mlcd_pkg::ST_MEM;
                    end else if (i_item.op == mlcd_pkg::OP_CLEAR) begin
                        n_state = mlcd_pkg::ST_CLEAR;
                    end
                end
            end
            mlcd_pkg::ST_MEM: n_state = mlcd_pkg::ST_FETCH;
            default:          n_state = mlcd_pkg::ST_FETCH;
        endcase
    end

    always_comb begin
        n_clr_addr  = r_clr_addr;
        n_vcom      = r_vcom;
        n_busy      = r_busy;
        n_kind      = r_kind;
        n_head      = r_head;
        n_first     = r_first;
        n_line      = r_line;
        n_slot      = r_slot;
        n_faddr     = r_faddr;
        n_pend      = r_pend;
        n_mask      = r_mask;
        n_color     = r_color;
        n_addr      = r_addr;
        n_rsp       = r_rsp;
        n_out_valid = r_out_valid && !o_rsp.ready;
        w_we        = 1'b0;
        w_waddr     = r_clr_addr;
        w_wdata     = mlcd_pkg::DUMMY_BYTE;
        w_raddr     = ((i_item.op == mlcd_pkg::OP_NEXT) && w_frame_data) ? r_faddr : w_paddr;
        w_rsp       = '0;
        w_rsp.accepted = 1'b1;

        case (r_state)
            mlcd_pkg::ST_CLEAR: begin
                w_we       = 1'b1;
                n_clr_addr = r_clr_addr + AW'(1);
            end
            mlcd_pkg::ST_FETCH: begin
                if (w_pop) begin
                    n_mask  = w_pmask;
                    n_color = i_item.color;
                    n_addr  = w_paddr;
                    n_pend  = (i_item.op == mlcd_pkg::OP_DRAW) ? mlcd_pkg::PEND_DRAW :
                              (i_item.op == mlcd_pkg::OP_READ) ? mlcd_pkg::PEND_READ :
                                                                 mlcd_pkg::PEND_FRAME;
                    case (i_item.op)
                        mlcd_pkg::OP_DRAW, mlcd_pkg::OP_READ: begin
                            // Out-of-range pixels answer at once with a zero read.
                        end
                        mlcd_pkg::OP_CLEAR: begin
                            n_clr_addr = '0;
                        end
                        mlcd_pkg::OP_UPDATE, mlcd_pkg::OP_TICK, mlcd_pkg::OP_PANEL: begin
                            if (r_busy) begin
                                w_rsp.accepted = 1'b0;
                            end else begin
                                n_busy  = 1'b1;
                                n_first = 1'b1;
                                n_line  = '0;
                                n_slot  = '0;
                                n_faddr = '0;
                                if (i_item.op == mlcd_pkg::OP_UPDATE) begin
                                    n_kind = mlcd_pkg::KIND_FRAME;
                                    n_head = r_vcom ? (mlcd_pkg::MODE_UPDATE | mlcd_pkg::VCOM_BIT)
                                                    : mlcd_pkg::MODE_UPDATE;
                                    n_vcom = ~r_vcom;
                                end else if (i_item.op == mlcd_pkg::OP_TICK) begin
                                    n_kind = mlcd_pkg::KIND_CMD;
                                    n_head = r_vcom ? mlcd_pkg::VCOM_BIT : mlcd_pkg::PAD_BYTE;
                                    n_vcom = ~r_vcom;
                                end else begin
                                    n_kind = mlcd_pkg::KIND_CMD;
                                    n_head = mlcd_pkg::CMD_CLEAR;
                                end
                            end
                        end
                        mlcd_pkg::OP_NEXT: begin
                            if (r_busy) begin
                                w_rsp.link_valid    = 1'b1;
                                w_rsp.select_active = 1'b1;
                                if (r_first) begin
                                    w_rsp.link_byte = r_head;
                                    n_first         = 1'b0;
                                end else if (r_kind != mlcd_pkg::KIND_FRAME) begin
                                    w_rsp.link_byte     = mlcd_pkg::PAD_BYTE;
                                    w_rsp.transfer_last = 1'b1;
                                end else if (r_line == LW'(LINES)) begin
                                    w_rsp.link_byte     = mlcd_pkg::DUMMY_BYTE;
                                    w_rsp.transfer_last = 1'b1;
                                end else if (r_slot == '0) begin
                                    w_rsp.link_byte = mlcd_pkg::bit_rev(r_line + LW'(1));
                                    n_slot          = r_slot + SLOT_W'(1);
                                end else if (w_frame_data) begin
                                    n_slot  = r_slot + SLOT_W'(1);
                                    n_faddr = r_faddr + AW'(1);
                                end else begin
                                    // Dummy byte closes the line.
                                    w_rsp.link_byte = mlcd_pkg::DUMMY_BYTE;
                                    n_slot          = '0;
                                    n_line          = r_line + LW'(1);
                                end
                                if (w_rsp.transfer_last) begin
                                    n_busy = 1'b0;
                                    n_kind = mlcd_pkg::KIND_IDLE;
                                end
                            end
                        end
                        default: begin
                            w_rsp.accepted = 1'b0;
                        end
                    endcase
                    if (!w_mem_op) begin
                        n_rsp       = w_rsp;
                        n_out_valid = 1'b1;
                    end
                end
            end
            mlcd_pkg::ST_MEM: begin
                case (r_pend)
                    mlcd_pkg::PEND_DRAW: begin
                        w_we    = 1'b1;
                        w_waddr = r_addr;
                        w_wdata = r_color ? (w_rdata & ~r_mask) : (w_rdata | r_mask);
                    end
                    mlcd_pkg::PEND_READ: begin
                        w_rsp.pixel_value = ~|(w_rdata & r_mask);
                    end
                    default: begin
                        w_rsp.link_valid    = 1'b1;
                        w_rsp.select_active = 1'b1;
                        w_rsp.link_byte     = w_rdata;
                    end
                endcase
                n_rsp       = w_rsp;
                n_out_valid = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_pend  <= n_pend;
        r_mask  <= n_mask;
        r_color <= n_color;
        r_addr  <= n_addr;
        r_rsp   <= n_rsp;
        if (!i_rst_n) begin
            r_state     <= mlcd_pkg::ST_CLEAR;
            r_clr_addr  <= '0;
            r_vcom      <= 1'b0;
            r_busy      <= 1'b0;
            r_kind      <= mlcd_pkg::KIND_IDLE;
            r_head      <= '0;
            r_first     <= 1'b0;
            r_line      <= '0;
            r_slot      <= '0;
            r_faddr     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_vcom      <= n_vcom;
            r_busy      <= n_busy;
            r_kind      <= n_kind;
            r_head      <= n_head;
            r_first     <= n_first;
            r_line      <= n_line;
            r_slot      <= n_slot;
            r_faddr     <= n_faddr;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.pixel_value   = r_rsp.pixel_value;
    assign o_rsp.accepted      = r_rsp.accepted;
    assign o_rsp.link_valid    = r_rsp.link_valid;
    assign o_rsp.link_byte     = r_rsp.link_byte;
    assign o_rsp.select_active = r_rsp.select_active;
    assign o_rsp.transfer_last = r_rsp.transfer_last;

endmodule

// ===== rtl/memory_lcd_frame_controller.sv =====
// Path: a taken word passes the two-slot queue and then the response register; pixel
// draws, pixel reads and frame data bytes also pass the store read register (ST_MEM).
// Throughput: one word per cycle while the receiver takes responses, but a word that
// reads the single store port holds the next one back. A store clear sweeps the store
// once, one byte per cycle. Reset is synchronous; after reset the same sweep runs
// before the first command word is taken.
module memory_lcd_frame_controller #(
    parameter int LINES          = 128,
    parameter int BYTES_PER_LINE = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mlcd_cmd_if.sink   i_cmd,
    mlcd_rsp_if.source o_rsp
);

    mlcd_pkg::t_back_status w_status;
    mlcd_pkg::t_cmd         w_push_item;
    mlcd_pkg::t_cmd         w_pop_item;
    logic                   w_push;
    logic                   w_queue_ready;
    logic                   w_queue_valid;
    logic                   w_pop;

    mlcd_front #(
        .LINES          (LINES),
        .BYTES_PER_LINE (BYTES_PER_LINE)
    ) u_front (
        .i_cmd         (i_cmd),
        .i_status      (w_status),
        .i_queue_ready (w_queue_ready),
        .o_push        (w_push),
        .o_item        (w_push_item)
    );

    mlcd_fifo u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_item),
        .o_ready (w_queue_ready),
        .o_valid (w_queue_valid),
        .o_data  (w_pop_item),
        .i_pop   (w_pop)
    );

    mlcd_back #(
        .LINES          (LINES),
        .BYTES_PER_LINE (BYTES_PER_LINE)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_queue_valid),
        .i_item   (w_pop_item),
        .o_pop    (w_pop),
        .o_status (w_status),
        .o_rsp    (o_rsp)
    );

endmodule

// ===== tb/sv/memory_lcd_frame_controller_tb.sv =====
`timescale 1ns / 1ps

module memory_lcd_frame_controller_tb;

    localparam int LINES       = 128;
    localparam int BPL         = 16;
    localparam int SLOT        = BPL + 2;
    localparam int FRAME_LEN   = 1 + LINES * SLOT + 1;
    localparam int STORE_BYTES = LINES * BPL;
    localparam int IDLE_ITEMS  = 300;
    localparam int HOLD_CYCLES = 400;
    localparam int STALL_LIMIT = 20000;
    localparam logic [7:0] ERASED = 8'hFF;

    logic i_clk;
    logic i_rst_n;

    mlcd_cmd_if cmd_bus ();
    mlcd_rsp_if rsp_bus ();

    memory_lcd_frame_controller #(
        .LINES          (LINES),
        .BYTES_PER_LINE (BPL)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_bus),
        .o_rsp   (rsp_bus)
    );

    typedef struct {
        mlcd_pkg::t_op  op;
        logic [6:0]     x;
        logic [6:0]     y;
        logic           color;
        bit             known;
        mlcd_pkg::t_rsp rsp;
    } t_row;

    // Shadow of the panel: store, VCOM phase and link transfer state.
    logic [7:0]      panel_bits [STORE_BYTES];
    logic            vcom_q;
    logic            link_on;
    mlcd_pkg::t_kind link_kind;
    int              link_pos;
    logic [7:0]      link_head;

    mlcd_pkg::t_rsp pending_rsp [$];
    t_row           script [$];

    // Link state as seen from the sender, so the generator knows what it is feeding.
    bit sent_link_busy;
    int sent_link_left;
    int sent_count;
    bit quiet;
    bit hold_request;
    bit hold_done;

    bit             cur_known;
    mlcd_pkg::t_rsp cur_rsp;
    int             errors;
    int             stall_cycles;
    mlcd_pkg::t_rsp model_rsp;
    mlcd_pkg::t_rsp want_rsp;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic mlcd_pkg::t_rsp rsp_of(input logic pix, input logic acc,
                                              input logic val, input logic [7:0] data,
                                              input logic sel, input logic last);
        mlcd_pkg::t_rsp r;
        r.pixel_value   = pix;
        r.accepted      = acc;
        r.link_valid    = val;
        r.link_byte     = data;
        r.select_active = sel;
        r.transfer_last = last;
        return r;
    endfunction

    function automatic logic [7:0] frame_out(input int p);
        int         q;
        int         line;
        int         slot_ix;
        logic [7:0] addr;
        logic [7:0] rev;
        if (p == 0) return link_head;
        if (p >= FRAME_LEN - 1) return ERASED;
        q       = p - 1;
        line    = q / SLOT;
        slot_ix = q % SLOT;
        if (slot_ix == 0) begin
            // Line addresses go out LSB first, so the byte is mirrored.
            addr = 8'(line + 1);
            for (int i = 0; i < 8; i++) rev[i] = addr[7-i];
            return rev;
        end
        if (slot_ix <= BPL) return panel_bits[line * BPL + slot_ix - 1];
        return ERASED;
    endfunction

    function automatic void start_link(input mlcd_pkg::t_kind kind, input logic [7:0] head);
        link_on   = 1'b1;
        link_kind = kind;
        link_pos  = 0;
        link_head = head;
    endfunction

    function automatic mlcd_pkg::t_rsp predict_response(input mlcd_pkg::t_op op,
                                                        input logic [6:0] px,
                                                        input logic [6:0] py,
                                                        input logic pc);
        mlcd_pkg::t_rsp r;
        int             cell_ix;
        bit             hit;
        logic [7:0]     bitmask;
        r          = '0;
        r.accepted = 1'b1;
        hit        = (int'(py) < LINES) && (int'(px[6:3]) < BPL);
        cell_ix    = int'(py) * BPL + int'(px[6:3]);
        bitmask    = mlcd_pkg::PIXEL_MSB >> px[2:0];
        case (op)
            mlcd_pkg::OP_DRAW: begin
                if (hit) begin
                    if (pc) panel_bits[cell_ix] = panel_bits[cell_ix] & ~bitmask;
                    else    panel_bits[cell_ix] = panel_bits[cell_ix] | bitmask;
                end
            end
            mlcd_pkg::OP_READ: begin
                if (hit) r.pixel_value = (panel_bits[cell_ix] & bitmask) == 8'h00;
            end
            mlcd_pkg::OP_CLEAR: begin
                foreach (panel_bits[i]) panel_bits[i] = ERASED;
            end
            mlcd_pkg::OP_UPDATE: begin
                if (link_on) r.accepted = 1'b0;
                else begin
                    start_link(mlcd_pkg::KIND_FRAME,
                               mlcd_pkg::MODE_UPDATE | (vcom_q ? mlcd_pkg::VCOM_BIT : 8'h00));
                    vcom_q = ~vcom_q;
                end
            end
            mlcd_pkg::OP_TICK: begin
                if (link_on) r.accepted = 1'b0;
                else begin
                    start_link(mlcd_pkg::KIND_CMD, vcom_q ? mlcd_pkg::VCOM_BIT : 8'h00);
                    vcom_q = ~vcom_q;
                end
            end
            mlcd_pkg::OP_PANEL: begin
                if (link_on) r.accepted = 1'b0;
                else start_link(mlcd_pkg::KIND_CMD, mlcd_pkg::CMD_CLEAR);
            end
            mlcd_pkg::OP_NEXT: begin
                if (link_on) begin
                    r.link_valid    = 1'b1;
                    r.select_active = 1'b1;
                    if (link_kind == mlcd_pkg::KIND_FRAME) begin
                        r.link_byte     = frame_out(link_pos);
                        r.transfer_last = link_pos >= FRAME_LEN - 1;
                    end else begin
                        r.link_byte     = (link_pos == 0) ? link_head : mlcd_pkg::PAD_BYTE;
                        r.transfer_last = link_pos >= 1;
                    end
                    if (r.transfer_last) begin
                        link_on   = 1'b0;
                        link_kind = mlcd_pkg::KIND_IDLE;
                        link_pos  = 0;
                    end else begin
                        link_pos++;
                    end
                end
            end
            default: r.accepted = 1'b0;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("ERROR at %0t ns: %s got 0x%0h, expected 0x%0h", $time, what, got, want);
        errors++;
    endtask

    task automatic add_row(input mlcd_pkg::t_op op, input logic [6:0] px,
                           input logic [6:0] py, input logic pc, input bit known,
                           input mlcd_pkg::t_rsp rsp);
        t_row row;
        row.op    = op;
        row.x     = px;
        row.y     = py;
        row.color = pc;
        row.known = known;
        row.rsp   = rsp;
        script.push_back(row);
    endtask

    // Called at a falling edge; returns at the falling edge after the word is taken.
    task automatic send(input mlcd_pkg::t_op op, input logic [6:0] px, input logic [6:0] py,
                        input logic pc, input bit known, input mlcd_pkg::t_rsp rsp);
        quiet = (sent_count >= 400) && (sent_count < 800);
        if (sent_count == 1200) hold_request = 1'b1;
        if (!quiet && $urandom_range(0, 99) < 15) begin
            cmd_bus.valid <= 1'b0;
            @(negedge i_clk);
            while ($urandom_range(0, 99) < 15) @(negedge i_clk);
        end
        cmd_bus.valid  <= 1'b1;
        cmd_bus.opcode <= op;
        cmd_bus.x      <= px;
        cmd_bus.y      <= py;
        cmd_bus.color  <= pc;
        cur_known      <= known;
        cur_rsp        <= rsp;
        @(posedge i_clk);
        while (!cmd_bus.ready) @(posedge i_clk);
        @(negedge i_clk);
        sent_count++;
        case (op)
            mlcd_pkg::OP_UPDATE: begin
                if (!sent_link_busy) begin
                    sent_link_busy = 1'b1;
                    sent_link_left = FRAME_LEN;
                end
            end
            mlcd_pkg::OP_TICK, mlcd_pkg::OP_PANEL: begin
                if (!sent_link_busy) begin
                    sent_link_busy = 1'b1;
                    sent_link_left = 2;
                end
            end
            mlcd_pkg::OP_NEXT: begin
                if (sent_link_busy) begin
                    sent_link_left--;
                    if (sent_link_left == 0) sent_link_busy = 1'b0;
                end
            end
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (cmd_bus.valid && cmd_bus.ready) begin
                model_rsp = predict_response(mlcd_pkg::t_op'(cmd_bus.opcode), cmd_bus.x,
                                             cmd_bus.y, cmd_bus.color);
                pending_rsp.push_back(cur_known ? cur_rsp : model_rsp);
            end
            if (rsp_bus.valid && rsp_bus.ready) begin
                if (pending_rsp.size() == 0) begin
                    report_mismatch("word with nothing expected, link_byte",
                                    rsp_bus.link_byte, 0);
                end else begin
                    want_rsp = pending_rsp.pop_front();
                    if (rsp_bus.pixel_value !== want_rsp.pixel_value)
                        report_mismatch("pixel_value", rsp_bus.pixel_value,
                                        want_rsp.pixel_value);
                    if (rsp_bus.accepted !== want_rsp.accepted)
                        report_mismatch("accepted", rsp_bus.accepted, want_rsp.accepted);
                    if (rsp_bus.link_valid !== want_rsp.link_valid)
                        report_mismatch("link_valid", rsp_bus.link_valid,
                                        want_rsp.link_valid);
                    if (rsp_bus.link_byte !== want_rsp.link_byte)
                        report_mismatch("link_byte", rsp_bus.link_byte, want_rsp.link_byte);
                    if (rsp_bus.select_active !== want_rsp.select_active)
                        report_mismatch("select_active", rsp_bus.select_active,
                                        want_rsp.select_active);
                    if (rsp_bus.transfer_last !== want_rsp.transfer_last)
                        report_mismatch("transfer_last", rsp_bus.transfer_last,
                                        want_rsp.transfer_last);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((cmd_bus.valid && cmd_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // Receiver: random back-pressure, plus one long hold so the block backs up.
    initial begin
        rsp_bus.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request && !hold_done) begin
                rsp_bus.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_done = 1'b1;
            end else begin
                rsp_bus.ready <= quiet || ($urandom_range(0, 99) >= 15);
            end
        end
    end

    initial begin
        mlcd_pkg::t_op  op;
        logic [6:0]     px;
        logic [6:0]     py;
        logic           pc;
        int             roll;
        int             idle_items;
        mlcd_pkg::t_rsp ack;
        mlcd_pkg::t_rsp refused;

        i_rst_n        = 1'b0;
        cmd_bus.valid  = 1'b0;
        cmd_bus.opcode = mlcd_pkg::OPC_DRAW;
        cmd_bus.x      = '0;
        cmd_bus.y      = '0;
        cmd_bus.color  = 1'b0;
        cur_known      = 1'b0;
        cur_rsp        = '0;
        errors         = 0;
        stall_cycles   = 0;
        sent_count     = 0;
        sent_link_busy = 1'b0;
        sent_link_left = 0;
        quiet          = 1'b0;
        hold_request   = 1'b0;
        hold_done      = 1'b0;
        idle_items     = 0;
        foreach (panel_bits[i]) panel_bits[i] = ERASED;
        vcom_q    = 1'b0;
        link_on   = 1'b0;
        link_kind = mlcd_pkg::KIND_IDLE;
        link_pos  = 0;
        link_head = 8'h00;

        ack     = rsp_of(1'b0, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0);
        refused = rsp_of(1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0);

        // Pixel corners on a freshly erased store.
        add_row(mlcd_pkg::OP_READ,   7'd0,   7'd0,   1'b0, 1, ack);
        add_row(mlcd_pkg::OP_DRAW,   7'd127, 7'd127, 1'b1, 1, ack);
        add_row(mlcd_pkg::OP_READ,   7'd127, 7'd127, 1'b0, 1, rsp_of(1, 1, 0, 8'h00, 0, 0));
        add_row(mlcd_pkg::OP_DRAW,   7'd0,   7'd0,   1'b1, 1, ack);
        add_row(mlcd_pkg::OP_READ,   7'd0,   7'd0,   1'b0, 1, rsp_of(1, 1, 0, 8'h00, 0, 0));
        add_row(mlcd_pkg::OP_DRAW,   7'd0,   7'd0,   1'b0, 1, ack);
        add_row(mlcd_pkg::OP_DRAW,   7'd42,  7'd85,  1'b1, 0, '0);
        // Next byte with the link idle, and the unused opcode.
        add_row(mlcd_pkg::OP_NEXT,   7'd0,   7'd0,   1'b0, 1, ack);
        add_row(mlcd_pkg::OP_BAD,    7'd0,   7'd0,   1'b0, 1, refused);
        // VCOM command, with every start command refused while it runs.
        add_row(mlcd_pkg::OP_TICK,   7'd0,   7'd0,   1'b0, 1, ack);
        add_row(mlcd_pkg::OP_UPDATE, 7'd0,   7'd0,   1'b0, 1, refused);
        add_row(mlcd_pkg::OP_TICK,   7'd0,   7'd0,   1'b0, 1, refused);
        add_row(mlcd_pkg::OP_PANEL,  7'd0,   7'd0,   1'b0, 1, refused);
        add_row(mlcd_pkg::OP_NEXT,   7'd0,   7'd0,   1'b0, 1, rsp_of(0, 1, 1, 8'h00, 1, 0));
        add_row(mlcd_pkg::OP_NEXT,   7'd0,   7'd0,   1'b0, 1, rsp_of(0, 1, 1, 8'h00, 1, 1));
        add_row(mlcd_pkg::OP_PANEL,  7'd0,   7'd0,   1'b0, 1, ack);
        add_row(mlcd_pkg::OP_NEXT,   7'd0,   7'd0,   1'b0, 1,
                rsp_of(0, 1, 1, mlcd_pkg::CMD_CLEAR, 1, 0));
        add_row(mlcd_pkg::OP_NEXT,   7'd0,   7'd0,   1'b0, 1, rsp_of(0, 1, 1, 8'h00, 1, 1));
        add_row(mlcd_pkg::OP_TICK,   7'd0,   7'd0,   1'b0, 1, ack);
        add_row(mlcd_pkg::OP_NEXT,   7'd0,   7'd0,   1'b0, 1,
                rsp_of(0, 1, 1, mlcd_pkg::VCOM_BIT, 1, 0));
        add_row(mlcd_pkg::OP_NEXT,   7'd0,   7'd0,   1'b0, 1, rsp_of(0, 1, 1, 8'h00, 1, 1));
        // Frame start: mode byte, then the mirrored address of line one.
        add_row(mlcd_pkg::OP_UPDATE, 7'd0,   7'd0,   1'b0, 1, ack);
        add_row(mlcd_pkg::OP_NEXT,   7'd0,   7'd0,   1'b0, 1,
                rsp_of(0, 1, 1, mlcd_pkg::MODE_UPDATE, 1, 0));
        add_row(mlcd_pkg::OP_NEXT,   7'd0,   7'd0,   1'b0, 1, rsp_of(0, 1, 1, 8'h80, 1, 0));
        add_row(mlcd_pkg::OP_CLEAR,  7'd0,   7'd0,   1'b0, 1, ack);

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (script[i])
            send(script[i].op, script[i].x, script[i].y, script[i].color,
                 script[i].known, script[i].rsp);

        // The frame started above runs to its trailer with pixel traffic mixed in,
        // then a stretch of short commands and pixel work with the link idle.
        while (sent_link_busy || idle_items < IDLE_ITEMS) begin
            roll = $urandom_range(0, 99);
            px   = 7'($urandom_range(0, 127));
            py   = 7'($urandom_range(0, 127));
            pc   = 1'($urandom_range(0, 1));
            if (sent_link_busy) begin
                if (roll < 90) op = mlcd_pkg::OP_NEXT;
                else if (roll < 96) op = (roll % 2) ? mlcd_pkg::OP_DRAW : mlcd_pkg::OP_READ;
                else if (roll < 99) begin
                    case ($urandom_range(0, 2))
                        0:       op = mlcd_pkg::OP_UPDATE;
                        1:       op = mlcd_pkg::OP_TICK;
                        default: op = mlcd_pkg::OP_PANEL;
                    endcase
                end else begin
                    op = ($urandom_range(0, 3) == 0) ? mlcd_pkg::OP_CLEAR : mlcd_pkg::OP_BAD;
                end
            end else begin
                idle_items++;
                if (roll < 25) op = (roll % 2) ? mlcd_pkg::OP_TICK : mlcd_pkg::OP_PANEL;
                else if (roll < 33) op = mlcd_pkg::OP_NEXT;
                else if (roll < 90) op = (roll % 2) ? mlcd_pkg::OP_DRAW : mlcd_pkg::OP_READ;
                else if (roll < 97) op = mlcd_pkg::OP_BAD;
                else op = mlcd_pkg::OP_CLEAR;
            end
            send(op, px, py, pc, 0, '0);
        end

        cmd_bus.valid <= 1'b0;
        while (pending_rsp.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
